[src/newton_square_root_top_defines.svh]
// Assertion macros shared by the square root block's modules.
`ifndef NEWTON_SQUARE_ROOT_TOP_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nsr: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nsr: next-cycle check failed");

`endif

[src/nsr_pkg.sv]
// Types, constants and widths shared by the square root block.
package nsr_pkg;

	// parameter defaults
	localparam int VALUE_WIDTH_DEF        = 32;
	localparam int FRACTION_BITS_DEF      = 16;
	localparam int WORK_FRACTION_BITS_DEF = 30;

	// working word of the shifter and divider
	localparam int WORD_W     = 64;
	localparam int WORD_LOG_W = $clog2(WORD_W);
	// signed shift amounts and exponent
	localparam int SHIFT_W    = 8;

	localparam int ROOT_W      = 24;
	localparam int STEPS_W     = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [ROOT_W-1:0]  ROOT_MAX    = '1;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd10;
	localparam logic               RANGE_RESET = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NEWTON_STEPS    = 2'd0,
		REG_RANGE_REDUCE_ON = 2'd1
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_UP,
		ST_DOWN,
		ST_LOAD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH,
		ST_DONE
	} state_t;

	// sequencer outputs
	typedef struct packed {
		logic take_item;
		logic div_start;
		logic shift_sel_x;
		logic out_load;
	} ctl_t;

endpackage

[src/nsr_shift.sv]
// Signed-amount shifter: saturating left shift, truncating right shift.
module nsr_shift
	import nsr_pkg::*;
(
	input  logic [WORD_W-1:0]         value,
	input  logic signed [SHIFT_W-1:0] amount,
	output logic [WORD_W-1:0]         result
);

	logic [SHIFT_W-1:0]    amt_u;
	logic [SHIFT_W-1:0]    mag;
	logic [2*WORD_W-1:0]   wide;
	logic                  left;
	logic                  far_left;
	logic                  far_right;

	// left for non-negative amounts, right by the magnitude otherwise
	always_comb begin
		amt_u     = amount;
		mag       = -amt_u;
		left      = !amount[SHIFT_W-1];
		far_left  = amt_u >= SHIFT_W'(WORD_W);
		far_right = mag >= SHIFT_W'(WORD_W);
		wide      = {{WORD_W{1'b0}}, value} << amt_u[WORD_LOG_W-1:0];
		if (left) begin
			if (value == '0)
				result = '0;
			else if (far_left || (|wide[2*WORD_W-1:WORD_W]))
				result = '1;
			else
				result = wide[WORD_W-1:0];
		end else if (far_right) begin
			result = '0;
		end else begin
			result = value >> mag[WORD_LOG_W-1:0];
		end
	end

endmodule

[src/nsr_div.sv]
// Radix-2 restoring divider, two-word dividend by one word, quotient saturated.
`include "newton_square_root_top_defines.svh"

module nsr_div
	import nsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend_hi,
	input  logic [WORD_W-1:0] dividend_lo,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [WORD_LOG_W-1:0] cnt_q;
	logic [WORD_W-1:0]     rem_q;
	logic [WORD_W-1:0]     low_q;
	logic [WORD_W-1:0]     div_q;
	logic [WORD_W-1:0]     quo_q;
	logic [WORD_W:0]       trial;
	logic                  fits;
	logic                  overflow;

	// high word at or above divisor: quotient needs more than one word
	// (a zero divisor lands here too and gives all ones)
	assign overflow = dividend_hi >= divisor;
	assign trial    = {rem_q, low_q[WORD_W-1]};
	assign fits     = trial >= {1'b0, div_q};

	// control: one quotient bit per cycle over the low word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (start && overflow) || (busy_q && cnt_q == '0);
			if (start) begin
				busy_q <= !overflow;
				cnt_q  <= WORD_LOG_W'(WORD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	// datapath: high word is the starting remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi;
			low_q <= dividend_lo;
			div_q <= divisor;
			quo_q <= overflow ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= fits ? WORD_W'(trial - {1'b0, div_q}) : trial[WORD_W-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[WORD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`NSR_ASSERT_IMPL(a_div_start_idle, clk, arst_n, start, !busy_q)
	`NSR_ASSERT_NEXT(a_div_done_pulse, clk, arst_n, done_q, !done_q)
	`NSR_ASSERT_NEXT(a_div_last_bit, clk, arst_n, busy_q && cnt_q == '0, done_q && !busy_q)

endmodule

[src/newton_square_root_top.sv]
// Square root of an unsigned Q16.16 item by range reduction and Newton steps.
// One item at a time: after acceptance the block searches the power-of-four
// scale (one compare per cycle), then runs newton_steps Newton steps, each a
// division by the shared radix-2 divider that makes one quotient bit per cycle
// over a 64-bit word. The reset value of newton_steps is 10. radicand_stall
// stays high until the sequencer is back in idle. The finished root sits in
// an output register, so the next item is accepted while it waits to be
// taken. Configuration is taken only while the sequencer is idle.
`include "newton_square_root_top_defines.svh"

module newton_square_root_top
	import nsr_pkg::*;
#(
	parameter int VALUE_WIDTH        = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS      = FRACTION_BITS_DEF,
	parameter int WORK_FRACTION_BITS = WORK_FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   radicand_valid,
	output logic                   radicand_stall,
	input  logic [VALUE_WIDTH-1:0] radicand,
	output logic                   root_valid,
	input  logic                   root_stall,
	output logic [ROOT_W-1:0]      root
);

	// 5 * radicand, and a power of two comfortably above it
	localparam int T_W = VALUE_WIDTH + 3;
	localparam int P_W = (VALUE_WIDTH + 5 > FRACTION_BITS + 4) ?
		VALUE_WIDTH + 5 : FRACTION_BITS + 4;

	state_t                    state_q;
	state_t                    state_d;
	ctl_t                      ctl;
	logic [STEPS_W-1:0]        steps_q;
	logic                      range_q;
	logic [VALUE_WIDTH-1:0]    r_q;
	logic [T_W-1:0]            t_q;
	logic [P_W-1:0]            p_q;
	logic signed [SHIFT_W-1:0] e_q;
	logic [WORD_W-1:0]         n_q;
	logic [WORD_W-1:0]         x_q;
	logic [STEPS_W-1:0]        cnt_q;
	logic [WORD_W-1:0]         res_q;
	logic [ROOT_W-1:0]         root_q;
	logic                      root_valid_q;
	logic                      out_free;
	logic                      up_go;
	logic                      down_go;
	logic                      last_step;
	logic                      r_zero;
	logic signed [SHIFT_W-1:0] sh_amt;
	logic [WORD_W-1:0]         sh_value;
	logic [WORD_W-1:0]         sh_result;
	logic [2*WORD_W-1:0]       dividend;
	logic                      div_done;
	logic [WORD_W-1:0]         div_quo;
	logic [WORD_W:0]           x_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RESET;
			range_q <= RANGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEWTON_STEPS:    steps_q <= cfg_data[STEPS_W-1:0];
				REG_RANGE_REDUCE_ON: range_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// status terms
	assign out_free  = !root_valid_q || !root_stall;
	assign up_go     = P_W'(t_q) > p_q;
	assign down_go   = P_W'(t_q) < (p_q >> 2);
	assign last_step = STEPS_W'(cnt_q + 1'b1) == steps_q;
	assign r_zero    = r_q == '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (radicand_valid) state_d = ST_PREP;
			ST_PREP: begin
				if (r_zero)       state_d = ST_DONE;
				else if (range_q) state_d = ST_UP;
				else              state_d = ST_LOAD;
			end
			ST_UP:       if (!up_go) state_d = ST_DOWN;
			ST_DOWN:     if (!down_go) state_d = ST_LOAD;
			ST_LOAD:     state_d = (steps_q == '0) ? ST_FINISH : ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = last_step ? ST_FINISH : ST_DIV_GO;
			ST_FINISH:   state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.take_item   = 1'b1;
			ST_DIV_GO: ctl.div_start   = 1'b1;
			ST_FINISH: ctl.shift_sel_x = 1'b1;
			ST_DONE:   ctl.out_load    = out_free;
			default:   ctl = '0;
		endcase
	end

	assign radicand_stall = !ctl.take_item;
	assign cfg_ready      = ctl.take_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// shared shifter: radicand into working format, or root back out
	always_comb begin
		if (ctl.shift_sel_x) begin
			sh_value = x_q;
			sh_amt   = e_q + SHIFT_W'(FRACTION_BITS - WORK_FRACTION_BITS);
		end else begin
			sh_value = WORD_W'(r_q);
			sh_amt   = SHIFT_W'(WORK_FRACTION_BITS - FRACTION_BITS) - (e_q <<< 1);
		end
	end

	nsr_shift u_shift (
		.value  (sh_value),
		.amount (sh_amt),
		.result (sh_result)
	);

	// n scaled by the working format is the two-word dividend
	assign dividend = {{WORD_W{1'b0}}, n_q} << WORK_FRACTION_BITS;

	nsr_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (ctl.div_start),
		.dividend_hi (dividend[2*WORD_W-1:WORD_W]),
		.dividend_lo (dividend[WORD_W-1:0]),
		.divisor     (x_q),
		.done        (div_done),
		.quotient    (div_quo)
	);

	// Newton update: mean of x and n/x, truncated
	assign x_sum = {1'b0, x_q} + {1'b0, div_quo};

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (radicand_valid) begin
					r_q <= radicand;
					t_q <= (T_W'(radicand) << 2) + T_W'(radicand);
				end
			end
			ST_PREP: begin
				p_q   <= P_W'(1) << (FRACTION_BITS + 3);
				e_q   <= '0;
				res_q <= '0;
			end
			ST_UP: begin
				if (up_go) begin
					p_q <= p_q << 2;
					e_q <= e_q + SHIFT_W'(1);
				end
			end
			ST_DOWN: begin
				if (down_go) begin
					p_q <= p_q >> 2;
					e_q <= e_q - SHIFT_W'(1);
				end
			end
			ST_LOAD: begin
				n_q   <= sh_result;
				x_q   <= WORD_W'(1) << WORK_FRACTION_BITS;
				cnt_q <= '0;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					x_q   <= x_sum[WORD_W:1];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_FINISH: res_q <= sh_result;
			default: ;
		endcase
	end

	// output register, root clamped to its field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			root_valid_q <= 1'b0;
		else if (ctl.out_load)
			root_valid_q <= 1'b1;
		else if (!root_stall)
			root_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load)
			root_q <= (|res_q[WORD_W-1:ROOT_W]) ? ROOT_MAX : res_q[ROOT_W-1:0];
	end

	assign root_valid = root_valid_q;
	assign root       = root_q;

	`NSR_ASSERT_NEXT(a_take_to_prep, clk, arst_n, radicand_valid && !radicand_stall, state_q == ST_PREP)
	`NSR_ASSERT_IMPL(a_step_in_range, clk, arst_n, state_q == ST_DIV_GO, cnt_q < steps_q)
	`NSR_ASSERT_IMPL(a_done_in_wait, clk, arst_n, div_done, state_q == ST_DIV_WAIT)

endmodule

[sim/tb_top.sv]
// Self-checking testbench for newton_square_root_top: predicted roots compared in order.
`timescale 1ns / 100ps

module tb_top
	import nsr_pkg::*;
();

	localparam int     VW           = VALUE_WIDTH_DEF;
	localparam int     FB           = FRACTION_BITS_DEF;
	localparam int     WFB          = WORK_FRACTION_BITS_DEF;
	localparam int     IDLE_PCT     = 23;
	localparam int     RANDOM_ITEMS = 850;
	localparam int     TAIL_CYCLES  = 200;
	localparam longint CYCLE_LIMIT  = 6000000;

	// indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	// extremes, unity, and values on both sides of the scaling bounds
	localparam logic [VW-1:0] EDGE_VALUES [16] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
		32'h0000_4000, 32'h0004_0000, 32'd26214,     32'd26215,
		32'd104857,    32'd104858,    32'h8000_0000, 32'h7FFF_FFFF,
		32'h0000_0002, 32'h0000_FFFF, 32'h00A0_0000, 32'h0006_6666
	};

	// Root predictor and queue of roots still owed by the block
	class sqrt_board;
		logic [ROOT_W-1:0]  roots_due[$];
		logic [STEPS_W-1:0] steps    = STEPS_RESET;
		logic               range_on = RANGE_RESET;
		int                 errors   = 0;

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_NEWTON_STEPS)
				steps = data[STEPS_W-1:0];
			else if (index == REG_RANGE_REDUCE_ON)
				range_on = data[0];
		endfunction

		// sign of v - 2^s
		function int pow2_cmp(logic [127:0] v, int s);
			logic [127:0] p;
			if (s < 0)
				return (v != 0) ? 1 : -1;
			if (s >= 128)
				return -1;
			p = 128'd1 << s;
			return (v > p) ? 1 : ((v < p) ? -1 : 0);
		endfunction

		// left shift saturating, right shift truncating
		function logic [63:0] scale64(logic [63:0] v, int s);
			if (s < 0)
				return (s <= -64) ? 64'd0 : (v >> (-s));
			if (v == 0)
				return 64'd0;
			if (s >= 64 || v > ({64{1'b1}} >> s))
				return {64{1'b1}};
			return v << s;
		endfunction

		function logic [ROOT_W-1:0] predict_root(logic [VW-1:0] r);
			logic [127:0] five_r;
			logic [127:0] num;
			logic [127:0] quot;
			logic [63:0]  n;
			logic [63:0]  x;
			logic [63:0]  q;
			logic [63:0]  wide_root;
			int           e;
			if (r == 0)
				return '0;
			five_r = 128'(r) * 128'd5;
			e = 0;
			// pick e so that r / 4^e lands in [2/5, 8/5]
			if (range_on) begin
				while (pow2_cmp(five_r, FB + 3 + 2 * e) > 0)
					e++;
				while (pow2_cmp(five_r, FB + 1 + 2 * e) < 0)
					e--;
			end
			n = scale64(64'(r), WFB - FB - 2 * e);
			num = 128'(n) << WFB;
			x = scale64(64'd1, WFB);
			// Newton steps, quotient truncated and saturated to 64 bits
			for (int i = 0; i < int'(steps); i++) begin
				if (x == 0)
					q = {64{1'b1}};
				else begin
					quot = num / 128'(x);
					q = (quot[127:64] != 0) ? {64{1'b1}} : quot[63:0];
				end
				x = (x >> 1) + (q >> 1) + {63'd0, x[0] & q[0]};
			end
			wide_root = scale64(x, e + FB - WFB);
			return (wide_root > 64'(ROOT_MAX)) ? ROOT_MAX : wide_root[ROOT_W-1:0];
		endfunction

		function void note_radicand(logic [VW-1:0] r);
			roots_due.push_back(predict_root(r));
		endfunction

		function void check_root(logic [ROOT_W-1:0] got);
			logic [ROOT_W-1:0] want;
			if (roots_due.size() == 0) begin
				errors++;
				$display("%0t: root expected none actual %h", $time, got);
				return;
			end
			want = roots_due.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: root expected %h actual %h", $time, want, got);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   radicand_valid;
	logic                   radicand_stall;
	logic [VW-1:0]          radicand;
	logic                   root_valid;
	logic                   root_stall = 1'b0;
	logic [ROOT_W-1:0]      root;

	sqrt_board board;
	bit        calm = 1'b0;
	longint    cycles = 0;

	newton_square_root_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.radicand_valid (radicand_valid),
		.radicand_stall (radicand_stall),
		.radicand       (radicand),
		.root_valid     (root_valid),
		.root_stall     (root_stall),
		.root           (root)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check taken items, then stall at random
	always @(posedge clk) begin
		if (root_valid && !root_stall)
			board.check_root(root);
		root_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Offer one radicand item, with a random gap first, and note it once taken
	task automatic send_radicand(input logic [VW-1:0] value);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				radicand_valid <= 1'b0;
				@(posedge clk);
			end
		end
		radicand_valid <= 1'b1;
		radicand <= value;
		@(posedge clk);
		while (radicand_stall)
			@(posedge clk);
		board.note_radicand(value);
	endtask

	// Stop sending and wait for every owed root
	task automatic drain();
		radicand_valid <= 1'b0;
		while (board.roots_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(index, data);
	endtask

	// New settings while idle; unused upper data bits are random
	task automatic configure(input logic [STEPS_W-1:0] steps, input logic range_on,
			input bit spare_too);
		logic [CFG_DATA_W-1:0] data;
		drain();
		data = CFG_DATA_W'($urandom);
		data[STEPS_W-1:0] = steps;
		write_reg(REG_NEWTON_STEPS, data);
		if (spare_too)
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
		data = CFG_DATA_W'($urandom);
		data[0] = range_on;
		write_reg(REG_RANGE_REDUCE_ON, data);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VW-1:0] random_radicand();
		case ($urandom_range(9))
			0:       return VW'($urandom_range(3));
			1, 2, 3: return VW'($urandom);
			4, 5, 6: return VW'($urandom) >> $urandom_range(VW - 1);
			7:       return (VW'(1) << $urandom_range(VW - 1)) + VW'($urandom_range(2)) - VW'(1);
			8:       return VW'($urandom_range(32'h0000_6666, 32'h0001_999A));
			default: return {VW{1'b1}} - VW'($urandom_range(15));
		endcase
	endfunction

	// Stimulus
	initial begin
		int          sent;
		int          chunk;
		int          phase;
		logic [STEPS_W-1:0] steps;

		board = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_NEWTON_STEPS;
		cfg_data <= '0;
		radicand_valid <= 1'b0;
		radicand <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes and scaling bounds
		foreach (EDGE_VALUES[k])
			send_radicand(EDGE_VALUES[k]);

		// zero steps: x stays at one
		configure(4'd0, 1'b1, 1'b1);
		send_radicand(32'h0000_0000);
		send_radicand(32'h0000_0001);
		send_radicand(32'hFFFF_FFFF);

		// no scaling, one step: root saturates for the largest radicand
		configure(4'd1, 1'b0, 1'b0);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0001_0000);

		// no scaling, most steps
		configure(4'd15, 1'b0, 1'b1);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0000_0000);

		// random phases, each drained before new settings
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(3))
				0:       steps = 4'd1;
				1:       steps = 4'd15;
				default: steps = STEPS_W'($urandom_range(15));
			endcase
			configure(steps, $urandom_range(3) != 0, $urandom_range(3) == 0);
			calm = (phase == 2);
			chunk = $urandom_range(40, 120);
			for (int i = 0; i < chunk && sent < RANDOM_ITEMS; i++) begin
				send_radicand(random_radicand());
				sent++;
			end
			phase++;
		end
		calm = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.roots_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
